>>> sv/sclm_pkg.sv
// Package for the sorted cut list with merge block.
// Holds the command codes, controller states, the list entry layout and register constants.
// No dependencies.
package sclm_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_MERGE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LAST,
    ST_FIND,
    ST_MRG_FIRST,
    ST_MRG
  } state_t;

  typedef struct packed {
    logic        [15:0] edge_id;
    logic signed [31:0] distance;
  } entry_t;

  localparam int GAP_W = 31;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_MERGE_GAP = 1'b0;
  localparam logic REG_BAD_GAP   = 1'b1;

  // Unsigned Q15.16: 0.2 and 0.1 units
  localparam logic [GAP_W-1:0] MERGE_GAP_RST = 31'd13107;
  localparam logic [GAP_W-1:0] BAD_GAP_RST   = 31'd6554;

endpackage

>>> sv/sorted_cut_list_with_merge_core.sv
// Sorted cut list with merge: top level, list memory, controller and register port.
// Depends on sclm_pkg.
//
// Clear, find on an empty list, merge on fewer than two entries and an insert into a
// full list report in the cycle after the request. Insert, find and merge walk the list
// one list entry per cycle through the single read port of the list memory; a new
// request is accepted only while busy is low, once the previous one has reported.
// Results pulse for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the list and restores the gap registers; the
// list memory itself is not cleared and only entries below the length are ever used.
module sorted_cut_list_with_merge_core
  import sclm_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_edge_id,
  input  logic signed [31:0] in_distance,
  // result channel
  output logic        out_valid,
  output logic        out_found,
  output logic [6:0]  out_entry_count,
  output logic        out_full_drop,
  output logic        out_order_error,
  output logic [5:0]  out_merged_count,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  // list memory
  entry_t mem [CAPACITY];
  logic [IW-1:0] rd_addr;
  entry_t        rd_data_r;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // registers
  logic [GAP_W-1:0] mrg_gap_r, bad_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrg_gap_r <= MERGE_GAP_RST;
      bad_gap_r <= BAD_GAP_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BAD_GAP) begin
        bad_gap_r <= pwdata[GAP_W-1:0];
      end else begin
        mrg_gap_r <= pwdata[GAP_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BAD_GAP) ? {1'b0, bad_gap_r} : {1'b0, mrg_gap_r};

  // controller state
  state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] kept_r, kept_nxt;
  logic [IW-1:0] removed_r, removed_nxt;
  logic          err_r, err_nxt;
  logic signed [31:0] kept_dist_r, kept_dist_nxt;
  logic [15:0]   new_edge_r, new_edge_nxt;
  logic signed [31:0] new_dist_r, new_dist_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r, out_found_nxt;
  logic [6:0]  out_count_r, out_count_nxt;
  logic        out_full_r, out_full_nxt;
  logic        out_err_r, out_err_nxt;
  logic [5:0]  out_merged_r, out_merged_nxt;

  logic               accept;
  logic               last_idx;
  logic signed [32:0] gap;
  logic signed [32:0] neg_bad;
  logic signed [32:0] pos_mrg;
  logic [IW-1:0]      kept_inc;
  logic [IW-1:0]      removed_inc;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign last_idx  = (LW'(idx_r) + LW'(1)) == len_r;
  assign gap       = $signed({rd_data_r.distance[31], rd_data_r.distance})
                   - $signed({kept_dist_r[31], kept_dist_r});
  assign neg_bad   = -$signed({2'b00, bad_gap_r});
  assign pos_mrg   = $signed({2'b00, mrg_gap_r});
  assign kept_inc    = kept_r + IW'(1);
  assign removed_inc = removed_r + IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    kept_r       <= kept_nxt;
    removed_r    <= removed_nxt;
    err_r        <= err_nxt;
    kept_dist_r  <= kept_dist_nxt;
    new_edge_r   <= new_edge_nxt;
    new_dist_r   <= new_dist_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_full_r   <= out_full_nxt;
    out_err_r    <= out_err_nxt;
    out_merged_r <= out_merged_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    kept_nxt       = kept_r;
    removed_nxt    = removed_r;
    err_nxt        = err_r;
    kept_dist_nxt  = kept_dist_r;
    new_edge_nxt   = new_edge_r;
    new_dist_nxt   = new_dist_r;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_full_nxt   = out_full_r;
    out_err_nxt    = out_err_r;
    out_merged_nxt = out_merged_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          new_edge_nxt   = in_edge_id;
          new_dist_nxt   = in_distance;
          out_found_nxt  = 1'b0;
          out_full_nxt   = 1'b0;
          out_err_nxt    = 1'b0;
          out_merged_nxt = '0;
          out_count_nxt  = 7'(len_r);
          unique case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (len_r == LW'(CAPACITY)) begin
                out_full_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
              end else if (len_r == '0) begin
                idx_nxt   = '0;
                state_nxt = ST_INS_LAST;
              end else begin
                // walk down from the tail, shifting larger entries up
                idx_nxt   = IW'(len_r - LW'(1));
                rd_addr   = IW'(len_r - LW'(1));
                state_nxt = ST_INS;
              end
            end
            CMD_FIND: begin
              if (len_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                rd_addr   = '0;
                state_nxt = ST_FIND;
              end
            end
            CMD_MERGE: begin
              if (len_r < LW'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_addr   = '0;
                state_nxt = ST_MRG_FIRST;
              end
            end
            CMD_CLEAR: begin
              len_nxt       = '0;
              out_count_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + IW'(1);
        if (new_dist_r < rd_data_r.distance) begin
          wr_data = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = ST_INS_LAST;
          end else begin
            idx_nxt = idx_r - IW'(1);
            rd_addr = idx_r - IW'(1);
          end
        end else begin
          wr_data.edge_id  = new_edge_r;
          wr_data.distance = new_dist_r;
          len_nxt       = len_r + LW'(1);
          out_count_nxt = 7'(len_r + LW'(1));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_INS_LAST: begin
        wr_en            = 1'b1;
        wr_addr          = idx_r;
        wr_data.edge_id  = new_edge_r;
        wr_data.distance = new_dist_r;
        len_nxt          = len_r + LW'(1);
        out_count_nxt    = 7'(len_r + LW'(1));
        out_valid_nxt    = 1'b1;
        state_nxt        = ST_IDLE;
      end

      ST_FIND: begin
        if (rd_data_r.edge_id == new_edge_r) begin
          out_found_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (last_idx) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          rd_addr = idx_r + IW'(1);
        end
      end

      ST_MRG_FIRST: begin
        kept_dist_nxt = rd_data_r.distance;
        kept_nxt      = '0;
        removed_nxt   = '0;
        err_nxt       = 1'b0;
        idx_nxt       = IW'(1);
        rd_addr       = IW'(1);
        state_nxt     = ST_MRG;
      end

      ST_MRG: begin
        // compact in place: write slot trails the read slot
        priority if (gap < neg_bad) begin
          err_nxt     = 1'b1;
          removed_nxt = removed_inc;
        end else if (gap > pos_mrg) begin
          kept_nxt      = kept_inc;
          kept_dist_nxt = rd_data_r.distance;
          wr_en         = 1'b1;
          wr_addr       = kept_inc;
          wr_data       = rd_data_r;
        end else begin
          removed_nxt = removed_inc;
        end
        if (last_idx) begin
          len_nxt        = LW'(kept_nxt) + LW'(1);
          out_count_nxt  = 7'(LW'(kept_nxt) + LW'(1));
          out_merged_nxt = 6'(removed_nxt);
          out_err_nxt    = err_nxt;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
          rd_addr = idx_r + IW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_entry_count  = out_count_r;
  assign out_full_drop    = out_full_r;
  assign out_order_error  = out_err_r;
  assign out_merged_count = out_merged_r;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result pulsed while a request is in progress");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_CLEAR) |=> out_valid_r && out_count_r == '0)
    else $error("clear did not report an empty list");

  a_merge_write_trails: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MRG |-> kept_r < idx_r)
    else $error("merge write slot caught up with the read slot");

  a_insert_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS |-> LW'(idx_r) < len_r && len_r < LW'(CAPACITY))
    else $error("insert walk outside the list");
`endif

endmodule
